### sv/cpac_pkg.sv
// ----------------------------------------------------------------------------
// cpac_pkg
// Shared types, widths, register indexes and constants for the chirp packet
// airtime calculator.
// ----------------------------------------------------------------------------
package cpac_pkg;

    localparam int LEN_W    = 8;
    localparam int AIR_W    = 26;
    localparam int SYM_W    = 10;
    localparam int BW_W     = 9;
    localparam int SF_W     = 4;
    localparam int CR_W     = 4;
    localparam int PRE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SF        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CR        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 2'd3;

    localparam logic [BW_W-1:0]  BW_RESET  = 9'd125;
    localparam logic [SF_W-1:0]  SF_RESET  = 4'd7;
    localparam logic [CR_W-1:0]  CR_RESET  = 4'd5;
    localparam logic [PRE_W-1:0] PRE_RESET = 16'd8;

    localparam logic [SF_W-1:0] SF_MIN = 4'd6;
    localparam logic [SF_W-1:0] SF_MAX = 4'd12;
    localparam logic [CR_W-1:0] CR_MIN = 4'd5;
    localparam logic [CR_W-1:0] CR_MAX = 4'd8;

    // Divider geometry
    localparam int DIVD_W          = 11;
    localparam int NUM_W           = 31;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Pipeline stage indexes
    localparam int ST_LEN   = 0;
    localparam int ST_X     = 1;
    localparam int ST_QEST  = 2;
    localparam int ST_Q     = 3;
    localparam int ST_SYM   = 4;
    localparam int ST_NUM4  = 5;
    localparam int ST_SHIFT = 6;
    localparam int ST_DIV0  = 7;
    localparam int NUM_STAGES = ST_DIV0 + DIV_STAGES + 1;
    localparam int ST_OUT   = NUM_STAGES - 1;

    typedef struct packed {
        logic [DIVD_W-1:0] rem;
        logic [NUM_W-1:0]  nq;
        logic [SYM_W-1:0]  sym;
    } div_stage_t;

    // floor(65536 / k) for symbol divisor k in 4..12
    function automatic logic [14:0] recip(input logic [SF_W-1:0] k);
        logic [14:0] r;
        case (k)
            4'd4:    r = 15'd16384;
            4'd5:    r = 15'd13107;
            4'd6:    r = 15'd10922;
            4'd7:    r = 15'd9362;
            4'd8:    r = 15'd8192;
            4'd9:    r = 15'd7281;
            4'd10:   r = 15'd6553;
            4'd11:   r = 15'd5957;
            4'd12:   r = 15'd5461;
            default: r = 15'd5461;
        endcase
        return r;
    endfunction

endpackage

### sv/cpac_if.sv
// ----------------------------------------------------------------------------
// cpac interfaces
// Valid/ready channels for queries, results and register writes.
// ----------------------------------------------------------------------------
interface cpac_query_if;
    logic                        valid;
    logic                        ready;
    logic [cpac_pkg::LEN_W-1:0]  payload_length;

    modport source (output valid, output payload_length, input ready);
    modport sink   (input valid, input payload_length, output ready);
endinterface

interface cpac_result_if;
    logic                        valid;
    logic                        ready;
    logic [cpac_pkg::AIR_W-1:0]  airtime_ms;
    logic [cpac_pkg::SYM_W-1:0]  payload_symbols;
    logic                        low_rate_mode;

    modport source (output valid, output airtime_ms, output payload_symbols,
                    output low_rate_mode, input ready);
    modport sink   (input valid, input airtime_ms, input payload_symbols,
                    input low_rate_mode, output ready);
endinterface

interface cpac_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cpac_pkg::CFG_IDX_W-1:0]   index;
    logic [cpac_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/chirp_packet_airtime_calc.sv
// ----------------------------------------------------------------------------
// chirp_packet_airtime_calc
// Pipeline: 7 front stages, 16 divider stages of up to two radix-2 steps
// each (one in the last), one output register. Throughput: one query per
// cycle unless stalled; bubbles collapse, a stalled result holds.
// Reset empties the pipeline and loads 125 kHz, SF7, rate 4/5, preamble 8.
// Computes packet airtime and payload symbol count from the configured link.
// ----------------------------------------------------------------------------
module chirp_packet_airtime_calc
(
    input  logic                  clk,
    input  logic                  rst_n,
    cpac_query_if.sink            query,
    cpac_result_if.source         result,
    cpac_cfg_if.sink              cfg
);

    // Configuration registers
    logic [cpac_pkg::BW_W-1:0]  bw_reg;
    logic [cpac_pkg::SF_W-1:0]  sf_reg;
    logic [cpac_pkg::CR_W-1:0]  cr_reg;
    logic [cpac_pkg::PRE_W-1:0] pre_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg  <= cpac_pkg::BW_RESET;
            sf_reg  <= cpac_pkg::SF_RESET;
            cr_reg  <= cpac_pkg::CR_RESET;
            pre_reg <= cpac_pkg::PRE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                cpac_pkg::REG_BANDWIDTH: bw_reg  <= cfg.data[cpac_pkg::BW_W-1:0];
                cpac_pkg::REG_SF:        sf_reg  <= cfg.data[cpac_pkg::SF_W-1:0];
                cpac_pkg::REG_CR:        cr_reg  <= cfg.data[cpac_pkg::CR_W-1:0];
                cpac_pkg::REG_PREAMBLE:  pre_reg <= cfg.data[cpac_pkg::PRE_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Derived link settings
    logic [cpac_pkg::BW_W-1:0]   bw_eff;
    logic [cpac_pkg::SF_W-1:0]   sf_c;
    logic [cpac_pkg::CR_W-1:0]   cr_c;
    logic                        de;
    logic [cpac_pkg::SF_W-1:0]   sym_k;
    logic [5:0]                  den;
    logic [5:0]                  neg;
    logic [cpac_pkg::DIVD_W-1:0] div_d;

    always_comb
    begin
        bw_eff = (bw_reg == '0) ? 9'd1 : bw_reg;
        if (sf_reg < cpac_pkg::SF_MIN)
            sf_c = cpac_pkg::SF_MIN;
        else if (sf_reg > cpac_pkg::SF_MAX)
            sf_c = cpac_pkg::SF_MAX;
        else
            sf_c = sf_reg;
        if (cr_reg < cpac_pkg::CR_MIN)
            cr_c = cpac_pkg::CR_MIN;
        else if (cr_reg > cpac_pkg::CR_MAX)
            cr_c = cpac_pkg::CR_MAX;
        else
            cr_c = cr_reg;
        de    = ((13'd1 << sf_c) > {bw_eff, 4'b0000});
        sym_k = sf_c - {2'b00, de, 1'b0};
        den   = {sym_k, 2'b00};
        neg   = {sf_c, 2'b00};
        div_d = {bw_eff, 2'b00};
    end

    // Stage control
    logic [cpac_pkg::NUM_STAGES-1:0] v_reg;
    logic [cpac_pkg::NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[cpac_pkg::ST_OUT] = !v_reg[cpac_pkg::ST_OUT] || result.ready;
        for (int i = cpac_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign query.ready = adv[cpac_pkg::ST_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= query.valid;
            for (int i = 1; i < cpac_pkg::NUM_STAGES; i++)
            begin
                if (adv[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Front stages
    logic [cpac_pkg::LEN_W-1:0]  len_reg;
    logic [9:0]                  x_reg;
    logic                        zero1_reg;
    logic [9:0]                  x2_reg;
    logic [7:0]                  qest_reg;
    logic                        zero2_reg;
    logic [7:0]                  q_reg;
    logic                        zero3_reg;
    logic [10:0]                 sym_reg;
    logic [18:0]                 num4_reg;
    logic [cpac_pkg::SYM_W-1:0]  sym5_reg;
    logic [cpac_pkg::NUM_W-1:0]  n_reg;
    logic [cpac_pkg::SYM_W-1:0]  sym6_reg;

    logic [11:0] pos;
    logic [11:0] m_next;
    logic        zero_next;
    logic [24:0] prod;
    logic [9:0]  rem_q;
    logic [7:0]  q_next;
    logic [10:0] sym_next;
    logic [18:0] num4_next;
    logic [cpac_pkg::SYM_W-1:0] sym_sat_next;

    always_comb
    begin
        pos          = {1'b0, len_reg, 3'b000} + 12'd44;
        zero_next    = (pos <= {6'd0, neg});
        m_next       = pos - {6'd0, neg} + {6'd0, den} - 12'd1;
        prod         = {15'd0, x_reg} * {10'd0, cpac_pkg::recip(sym_k)};
        rem_q        = x2_reg - ({2'b00, qest_reg} * {6'd0, sym_k});
        q_next       = (rem_q >= {6'd0, sym_k}) ? (qest_reg + 8'd1) : qest_reg;
        sym_next     = zero3_reg ? 11'd0 : ({3'b000, q_reg} * {7'd0, cr_c});
        num4_next    = {1'b0, pre_reg, 2'b00} + 19'd49 + {6'd0, sym_reg, 2'b00};
        sym_sat_next = sym_reg[10] ? '1 : sym_reg[cpac_pkg::SYM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[cpac_pkg::ST_LEN])
            len_reg <= query.payload_length;
        if (adv[cpac_pkg::ST_X])
        begin
            x_reg     <= m_next[11:2];
            zero1_reg <= zero_next;
        end
        if (adv[cpac_pkg::ST_QEST])
        begin
            x2_reg    <= x_reg;
            qest_reg  <= prod[23:16];
            zero2_reg <= zero1_reg;
        end
        if (adv[cpac_pkg::ST_Q])
        begin
            q_reg     <= q_next;
            zero3_reg <= zero2_reg;
        end
        if (adv[cpac_pkg::ST_SYM])
            sym_reg <= sym_next;
        if (adv[cpac_pkg::ST_NUM4])
        begin
            num4_reg <= num4_next;
            sym5_reg <= sym_sat_next;
        end
        if (adv[cpac_pkg::ST_SHIFT])
        begin
            n_reg    <= {12'd0, num4_reg} << sf_c;
            sym6_reg <= sym5_reg;
        end
    end

    // Restoring divider, two quotient bits a stage (one in the last stage)
    cpac_pkg::div_stage_t div_reg  [cpac_pkg::DIV_STAGES];
    cpac_pkg::div_stage_t div_next [cpac_pkg::DIV_STAGES];

    always_comb
    begin
        cpac_pkg::div_stage_t cur;
        logic [cpac_pkg::DIVD_W:0] t;
        for (int s = 0; s < cpac_pkg::DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                cur.rem = '0;
                cur.nq  = n_reg;
                cur.sym = sym6_reg;
            end
            else
            begin
                cur = div_reg[s-1];
            end
            for (int j = 0; j < cpac_pkg::STEPS_PER_STAGE; j++)
            begin
                if (s * cpac_pkg::STEPS_PER_STAGE + j < cpac_pkg::NUM_W)
                begin
                    t = {cur.rem, cur.nq[cpac_pkg::NUM_W-1]};
                    if (t >= {1'b0, div_d})
                    begin
                        t      = t - {1'b0, div_d};
                        cur.nq = {cur.nq[cpac_pkg::NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        cur.nq = {cur.nq[cpac_pkg::NUM_W-2:0], 1'b0};
                    end
                    cur.rem = t[cpac_pkg::DIVD_W-1:0];
                end
            end
            div_next[s] = cur;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < cpac_pkg::DIV_STAGES; s++)
        begin
            if (adv[cpac_pkg::ST_DIV0 + s])
                div_reg[s] <= div_next[s];
        end
    end

    // Output register
    cpac_pkg::div_stage_t last_div;
    logic [cpac_pkg::AIR_W-1:0] air_reg;
    logic [cpac_pkg::SYM_W-1:0] sym_out_reg;
    logic                       de_reg;

    assign last_div = div_reg[cpac_pkg::DIV_STAGES-1];

    always_ff @(posedge clk)
    begin
        if (adv[cpac_pkg::ST_OUT])
        begin
            air_reg     <= (last_div.nq[cpac_pkg::NUM_W-1:cpac_pkg::AIR_W] != '0)
                           ? '1 : last_div.nq[cpac_pkg::AIR_W-1:0];
            sym_out_reg <= last_div.sym;
            de_reg      <= de;
        end
    end

    assign result.valid           = v_reg[cpac_pkg::ST_OUT];
    assign result.airtime_ms      = air_reg;
    assign result.payload_symbols = sym_out_reg;
    assign result.low_rate_mode   = de_reg;

endmodule
